>>> src/gef_pkg.sv
`default_nettype none
package gef_pkg;

   // Result queue between the front and back halves
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = 3;

   // floor(x / 1000) == (x * LUMA_RECIP) >> LUMA_SHIFT for every x below 2^18
   localparam logic [18:0] LUMA_RECIP = 19'd268436;
   localparam int          LUMA_SHIFT = 28;

   typedef enum logic {
      PHASE_FIRST,
      PHASE_BORDER
   } gef_phase_type;

   // win[0] oldest column, win[2] newest; each column holds rows r-2, r-1, r
   // in bits 7:0, 15:8, 23:16
   typedef struct packed {
      logic [2:0][23:0] win;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [11:0]      row;
      logic [9:0]       col;
      logic             interior;
      logic             border;
   } gef_entry_type;

endpackage
`default_nettype wire

>>> src/gradient_edge_filter_3x3.sv
`default_nettype none
// 3x3 gradient edge filter. RGB pixels stream in raster order and one pixel
// is taken per clock while the queue has room; a pixel goes through the
// front-end registers, result queue and output register to rsp. Each pixel
// gives zero, one or two results: a border pixel comes out as its own channels
// doubled and saturated, and an interior pixel (r-1,c-1) comes out, with its
// coordinates, when pixel (r,c) arrives, ahead of any border result for (r,c);
// rsp_tlast marks the last result of a pixel. The output register sends one
// result per clock unless stalled, so a pixel with two results holds the back
// end for both, and an eight-entry queue between the luma/line-buffer front end
// and the output stage absorbs that. Two luma lines live in one MAX_WIDTH-entry
// memory that is not cleared at reset; only columns already written in the
// current geometry are meaningful. frame_width and frame_height are clamped
// to at least 3 (width at most MAX_WIDTH) and should only be written while no
// pixel is in flight.
module gradient_edge_filter_3x3 #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,    // red, green, blue

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,    // out_row, out_col, out_red,
                                          // out_green, out_blue, zero pad
   output logic             rsp_tlast,    // last_of_run

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import gef_pkg::*;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   logic [10:0]           frame_width_ff;
   logic [11:0]           frame_height_ff;
   logic                  csr_write;

   logic                  push;
   gef_entry_type         push_entry;
   logic                  pop;
   logic                  head_valid;
   gef_entry_type         head;
   logic [QUEUE_AW:0]     queue_level;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 12'd480;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[10:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = {21'd0, frame_width_ff};
         REG_FRAME_HEIGHT: csr_prdata = {20'd0, frame_height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   gef_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .queue_level  (queue_level),
      .push         (push),
      .push_entry   (push_entry)
   );

   gef_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .level      (queue_level)
   );

   gef_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // the ready gating must leave room for every pixel still in the front end
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (queue_level < (QUEUE_AW + 1)'(QUEUE_DEPTH)))
      else $error("result queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("result queue read while empty");

   // the border result of a two-result pixel follows right behind the interior one
   a_second_result_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("second result of a pixel not ready after first transfer");

endmodule
`default_nettype wire

>>> src/gef_front.sv
`default_nettype none
module gef_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [10:0]             frame_width,
   input  wire logic [11:0]             frame_height,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [23:0]             req_tdata,   // red, green, blue
   input  wire logic [gef_pkg::QUEUE_AW:0] queue_level,
   output logic                         push,
   output gef_pkg::gef_entry_type       push_entry
);
   import gef_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int XW = (CW + 1 > 11) ? CW + 1 : 11;

   logic [XW-1:0] fw_x;
   logic [XW-1:0] w_x;
   logic [CW:0]   w;
   logic [11:0]   h;
   logic          accept;

   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [11:0]   row_cnt_ff, row_cnt_in;
   logic          wrap0;
   logic [CW-1:0] c0;
   logic [12:0]   r_t;
   logic [11:0]   r0;
   logic [CW:0]   c1;
   logic [12:0]   rn;
   logic          end_row;
   logic          is_int;
   logic          is_bor;
   logic [CW+9:0] c0_x;
   logic [17:0]   sum_in;

   logic          v1_ff;
   logic [17:0]   sum1_ff;
   logic [CW-1:0] addr1_ff;
   logic [11:0]   row1_ff;
   logic [9:0]    col1_ff;
   logic          int1_ff;
   logic          bor1_ff;
   logic [23:0]   rgb1_ff;
   logic [15:0]   line_rd_ff;
   logic [36:0]   prod;

   logic          v2_ff;
   logic [7:0]    luma2_ff;
   logic [7:0]    above1_2_ff;
   logic [7:0]    above2_2_ff;
   logic [CW-1:0] addr2_ff;
   logic [11:0]   row2_ff;
   logic [9:0]    col2_ff;
   logic          int2_ff;
   logic          bor2_ff;
   logic [23:0]   rgb2_ff;

   logic [2:0][23:0] win_ff;
   logic [23:0]      new_col;

   // line buffer: bits 7:0 row r-1, bits 15:8 row r-2
   logic [15:0] line_mem [0:MAX_WIDTH-1];

   // geometry; frame_height is 12 bits so it never exceeds the height limit
   always_comb begin
      fw_x = XW'(frame_width);
      if (fw_x < XW'(3)) begin
         w_x = XW'(3);
      end else if (fw_x > XW'(MAX_WIDTH)) begin
         w_x = XW'(MAX_WIDTH);
      end else begin
         w_x = fw_x;
      end
      w = w_x[CW:0];
      h = (frame_height < 12'd3) ? 12'd3 : frame_height;
   end

   // room for this pixel plus everything still in the front stages
   assign req_tready = (5'(queue_level) + 5'(v1_ff) + 5'(v2_ff)) < 5'(QUEUE_DEPTH);
   assign accept     = req_tvalid & req_tready;

   // position of the arriving pixel; counters may be out of range after a
   // geometry change, so fold them first
   always_comb begin
      wrap0 = {1'b0, col_cnt_ff} >= w;
      c0    = wrap0 ? '0 : col_cnt_ff;
      r_t   = wrap0 ? ({1'b0, row_cnt_ff} + 13'd1) : {1'b0, row_cnt_ff};
      r0    = (r_t >= {1'b0, h}) ? 12'd0 : r_t[11:0];

      c1      = {1'b0, c0} + 1'b1;
      end_row = c1 >= w;
      rn      = {1'b0, r0} + 13'd1;
      if (end_row) begin
         col_cnt_in = '0;
         row_cnt_in = (rn >= {1'b0, h}) ? 12'd0 : rn[11:0];
      end else begin
         col_cnt_in = c1[CW-1:0];
         row_cnt_in = r0;
      end

      is_int = (r0 >= 12'd2) && (c0 >= CW'(2));
      is_bor = (r0 == 12'd0) || (r0 == h - 12'd1) || (c0 == '0) ||
               ({1'b0, c0} == w - 1'b1);
      c0_x   = {10'd0, c0};

      sum_in = 18'(req_tdata[7:0])   * 18'd299 +
               18'(req_tdata[15:8])  * 18'd587 +
               18'(req_tdata[23:16]) * 18'd114;
   end

   assign prod = 37'(sum1_ff) * 37'(LUMA_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         win_ff     <= '0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
         end
         if (v2_ff) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= new_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sum1_ff    <= sum_in;
         addr1_ff   <= c0;
         row1_ff    <= r0;
         col1_ff    <= c0_x[9:0];
         int1_ff    <= is_int;
         bor1_ff    <= is_bor;
         rgb1_ff    <= req_tdata;
         line_rd_ff <= line_mem[c0];
      end
      if (v1_ff) begin
         luma2_ff    <= prod[LUMA_SHIFT +: 8];
         above1_2_ff <= line_rd_ff[7:0];
         above2_2_ff <= line_rd_ff[15:8];
         addr2_ff    <= addr1_ff;
         row2_ff     <= row1_ff;
         col2_ff     <= col1_ff;
         int2_ff     <= int1_ff;
         bor2_ff     <= bor1_ff;
         rgb2_ff     <= rgb1_ff;
      end
      // the same column is read again no sooner than three pixels later
      if (v2_ff) begin
         line_mem[addr2_ff] <= {above1_2_ff, luma2_ff};
      end
   end

   assign new_col = {luma2_ff, above1_2_ff, above2_2_ff};

   always_comb begin
      push                = v2_ff;
      push_entry.win[0]   = win_ff[1];
      push_entry.win[1]   = win_ff[2];
      push_entry.win[2]   = new_col;
      push_entry.red      = rgb2_ff[7:0];
      push_entry.green    = rgb2_ff[15:8];
      push_entry.blue     = rgb2_ff[23:16];
      push_entry.row      = row2_ff;
      push_entry.col      = col2_ff;
      push_entry.interior = int2_ff;
      push_entry.border   = bor2_ff;
   end

endmodule
`default_nettype wire

>>> src/gef_queue.sv
`default_nettype none
module gef_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire gef_pkg::gef_entry_type     push_entry,
   input  wire logic                       pop,
   output logic                            head_valid,
   output gef_pkg::gef_entry_type          head,
   output logic [gef_pkg::QUEUE_AW:0]      level
);
   import gef_pkg::*;

   gef_entry_type         slot_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;
   logic [QUEUE_AW:0]     count_in;

   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];
   assign level      = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> src/gef_back.sv
`default_nettype none
module gef_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire gef_pkg::gef_entry_type head,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [47:0]                 rsp_tdata,   // out_row, out_col, out_red,
                                                    // out_green, out_blue, zero pad
   output logic                        rsp_tlast    // last_of_run
);
   import gef_pkg::*;

   gef_phase_type state_ff, state_in;

   logic        valid_ff, valid_in;
   logic [11:0] row_ff, row_in;
   logic [9:0]  col_ff, col_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;
   logic        last_ff, last_in;

   logic [10:0] h_left, h_right, v_below, v_above;
   logic [10:0] h_abs, v_abs;
   logic [7:0]  h_sat, v_sat;
   logic [8:0]  mag_sum;
   logic [7:0]  mag;
   logic        emit_int, emit_bor, can_load, fire;

   function automatic logic [7:0] lum(input logic [2:0][23:0] win,
                                      input int col, input int row);
      return win[col][8*row +: 8];
   endfunction

   function automatic logic [10:0] wsum(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      return 11'(a) + 11'({b, 1'b0}) + 11'(b) + 11'(c);
   endfunction

   function automatic logic [7:0] dbl(input logic [7:0] x);
      return x[7] ? 8'd255 : {x[6:0], 1'b0};
   endfunction

   // gradient magnitude of the window held in the head entry
   always_comb begin
      h_left  = wsum(lum(head.win, 0, 0), lum(head.win, 0, 1), lum(head.win, 0, 2));
      h_right = wsum(lum(head.win, 2, 0), lum(head.win, 2, 1), lum(head.win, 2, 2));
      v_below = wsum(lum(head.win, 0, 2), lum(head.win, 1, 2), lum(head.win, 2, 2));
      v_above = wsum(lum(head.win, 0, 0), lum(head.win, 1, 0), lum(head.win, 2, 0));
      h_abs   = (h_left >= h_right) ? h_left - h_right : h_right - h_left;
      v_abs   = (v_below >= v_above) ? v_below - v_above : v_above - v_below;
      h_sat   = (h_abs > 11'd255) ? 8'd255 : h_abs[7:0];
      v_sat   = (v_abs > 11'd255) ? 8'd255 : v_abs[7:0];
      mag_sum = 9'(h_sat) + 9'(v_sat);
      mag     = mag_sum[8] ? 8'd255 : mag_sum[7:0];
   end

   // an entry with both results sends the interior one first
   always_comb begin
      emit_int = head_valid && head.interior && (state_ff == PHASE_FIRST);
      emit_bor = head_valid && head.border &&
                 ((state_ff == PHASE_BORDER) || !head.interior);
      can_load = !valid_ff || rsp_tready;
      fire     = (emit_int || emit_bor) && can_load;
      pop      = head_valid && ((!head.interior && !head.border) ||
                                (fire && (emit_bor || !head.border)));

      state_in = state_ff;
      unique case (state_ff)
         PHASE_FIRST: begin
            if (fire && emit_int && head.border) begin
               state_in = PHASE_BORDER;
            end
         end
         PHASE_BORDER: begin
            if (pop) begin
               state_in = PHASE_FIRST;
            end
         end
         default: state_in = PHASE_FIRST;
      endcase

      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      if (emit_int) begin
         row_in   = head.row - 12'd1;
         col_in   = head.col - 10'd1;
         red_in   = mag;
         green_in = mag;
         blue_in  = mag;
         last_in  = !head.border;
      end else begin
         row_in   = head.row;
         col_in   = head.col;
         red_in   = dbl(head.red);
         green_in = dbl(head.green);
         blue_in  = dbl(head.blue);
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PHASE_FIRST;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, blue_ff, green_ff, red_ff, col_ff, row_ff};
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

>>> tb/sv/tb_gradient_edge_filter_3x3.sv
`timescale 1ns / 1ps

module tb_gradient_edge_filter_3x3;

   typedef enum logic {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [11:0] row;
      logic [9:0]  col;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last;
   } edge_px_type;

   localparam logic [31:0] WIDTH_MASK  = 32'h0000_07FF;
   localparam logic [31:0] HEIGHT_MASK = 32'h0000_0FFF;
   localparam int unsigned LINE_DEPTH  = 1024;
   localparam int unsigned ROW_LIMIT   = 4096;
   localparam int unsigned RANDOM_PIXELS = 720;
   localparam int unsigned WIDE_PIXELS   = 200;
   localparam logic [7:0]  WHITE = 8'hFF;
   localparam logic [7:0]  BLACK = 8'h00;

   // Tracks frame position, line buffers and luma window; queues the edge
   // pixels each accepted input should produce and matches outputs against them.
   class edge_output_tracker;
      logic [31:0]    width_reg;
      logic [31:0]    height_reg;
      logic [7:0]     line_up1 [0:LINE_DEPTH-1];
      logic [7:0]     line_up2 [0:LINE_DEPTH-1];
      int             win [0:2][0:2];   // [column][row], column 0 oldest
      int unsigned    col_pos;
      int unsigned    row_pos;
      edge_px_type    pending_px [$];
      int unsigned    errors;

      function new();
         int i;
         width_reg  = 640;
         height_reg = 480;
         for (i = 0; i < LINE_DEPTH; i++) begin
            line_up1[i] = 8'd0;
            line_up2[i] = 8'd0;
         end
         for (i = 0; i < 9; i++)
            win[i / 3][i % 3] = 0;
         col_pos = 0;
         row_pos = 0;
         errors  = 0;
      endfunction

      function void note_config(csr_index_type idx, logic [31:0] value);
         if (idx == REG_FRAME_WIDTH)
            width_reg = value & WIDTH_MASK;
         else
            height_reg = value & HEIGHT_MASK;
      endfunction

      function int unsigned width_eff();
         if (width_reg < 3) return 3;
         if (width_reg > LINE_DEPTH) return LINE_DEPTH;
         return width_reg;
      endfunction

      function int unsigned height_eff();
         if (height_reg < 3) return 3;
         if (height_reg > ROW_LIMIT) return ROW_LIMIT;
         return height_reg;
      endfunction

      // next pixel lands on (0,0) once the counters are folded into the geometry
      function bit at_frame_start();
         int unsigned c;
         int unsigned r;
         c = col_pos;
         r = row_pos;
         if (c >= width_eff()) begin
            c = 0;
            r++;
         end
         if (r >= height_eff()) r = 0;
         return (c == 0) && (r == 0);
      endfunction

      function int unsigned clip_abs(int v);
         if (v < 0) v = -v;
         return (v > 255) ? 255 : v;
      endfunction

      function logic [7:0] twice_sat(logic [7:0] v);
         return (v > 8'd127) ? 8'hFF : {v[6:0], 1'b0};
      endfunction

      function void take_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         int unsigned w;
         int unsigned h;
         int unsigned luma;
         int unsigned k;
         int          gh;
         int          gv;
         int          wt;
         int unsigned mag;
         bit          has_inner;
         bit          has_border;
         edge_px_type inner_px;
         edge_px_type border_px;
         w = width_eff();
         h = height_eff();
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;

         luma = (299 * red + 587 * green + 114 * blue) / 1000;
         for (k = 0; k < 2; k++) begin
            win[k][0] = win[k+1][0];
            win[k][1] = win[k+1][1];
            win[k][2] = win[k+1][2];
         end
         win[2][0] = line_up2[col_pos];
         win[2][1] = line_up1[col_pos];
         win[2][2] = luma;
         line_up2[col_pos] = line_up1[col_pos];
         line_up1[col_pos] = luma[7:0];

         has_inner  = (row_pos >= 2) && (col_pos >= 2);
         has_border = (row_pos == 0) || (row_pos == h - 1) ||
                      (col_pos == 0) || (col_pos == w - 1);
         if (has_inner) begin
            gh = 0;
            gv = 0;
            for (k = 0; k < 3; k++) begin
               wt = (k == 1) ? 3 : 1;
               gh += wt * (win[0][k] - win[2][k]);
               gv += wt * (win[k][2] - win[k][0]);
            end
            mag = clip_abs(gh) + clip_abs(gv);
            if (mag > 255) mag = 255;
            inner_px.row   = 12'(row_pos - 1);
            inner_px.col   = 10'(col_pos - 1);
            inner_px.red   = mag[7:0];
            inner_px.green = mag[7:0];
            inner_px.blue  = mag[7:0];
            inner_px.last  = !has_border;
            pending_px.push_back(inner_px);
         end
         if (has_border) begin
            border_px.row   = 12'(row_pos);
            border_px.col   = 10'(col_pos);
            border_px.red   = twice_sat(red);
            border_px.green = twice_sat(green);
            border_px.blue  = twice_sat(blue);
            border_px.last  = 1'b1;
            pending_px.push_back(border_px);
         end

         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
         if (exp_v != got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v,
                     got_v);
            errors++;
         end
      endfunction

      function void match_output(edge_px_type got);
         edge_px_type exp_px;
         if (pending_px.size() == 0) begin
            $display("%0t: unexpected output: expected none, actual row %0d col %0d",
                     $time, got.row, got.col);
            errors++;
            return;
         end
         exp_px = pending_px.pop_front();
         compare_field("out_row", exp_px.row, got.row);
         compare_field("out_col", exp_px.col, got.col);
         compare_field("out_red", exp_px.red, got.red);
         compare_field("out_green", exp_px.green, got.green);
         compare_field("out_blue", exp_px.blue, got.blue);
         compare_field("last_of_run", exp_px.last, got.last);
      endfunction

      function int unsigned pending();
         return pending_px.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;     // red, green, blue
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;     // out_row, out_col, out_red, out_green, out_blue, pad
   logic        rsp_tlast;     // last_of_run
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   edge_output_tracker tracker;
   edge_px_type        seen_px;
   bit                 quiet;
   bit                 hold_long;
   int unsigned        pixels_sent;

   gradient_edge_filter_3x3 i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned pause_len();
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 7))
         0: return BLACK;
         1: return WHITE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // monitors: sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.take_pixel(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready) begin
            seen_px.row   = rsp_tdata[11:0];
            seen_px.col   = rsp_tdata[21:12];
            seen_px.red   = rsp_tdata[29:22];
            seen_px.green = rsp_tdata[37:30];
            seen_px.blue  = rsp_tdata[45:38];
            seen_px.last  = rsp_tlast;
            tracker.match_output(seen_px);
         end
      end
   end

   // output side: random back-pressure, plus one long hold-off on request
   initial begin
      int unsigned gap;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_long = 1'b0;
         end else begin
            gap = pause_len();
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      int unsigned gap;
      gap = pause_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic send_noise(input int unsigned count);
      repeat (count) send_pixel(pick_channel(), pick_channel(), pick_channel());
   endtask

   task automatic align_frame();
      while (!tracker.at_frame_start()) send_noise(1);
   endtask

   // drain outputs, then leave room for pixels that produce nothing
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == REG_FRAME_WIDTH) ? WIDTH_MASK : HEIGHT_MASK;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= ($urandom & ~mask) | (value & mask);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.note_config(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read_check(input csr_index_type idx);
      logic [31:0] exp_v;
      logic [31:0] got_v;
      exp_v = (idx == REG_FRAME_WIDTH) ? tracker.width_reg : tracker.height_reg;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got_v = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got_v != exp_v) begin
         $display("%0t: register %s mismatch: expected %0d, actual %0d", $time,
                  idx.name(), exp_v, got_v);
         tracker.errors++;
      end
   endtask

   task automatic program_geometry(input int unsigned w_raw, input int unsigned h_raw);
      wait_idle();
      csr_write(REG_FRAME_WIDTH, w_raw);
      csr_write(REG_FRAME_HEIGHT, h_raw);
      csr_read_check(REG_FRAME_WIDTH);
      csr_read_check(REG_FRAME_HEIGHT);
   endtask

   initial begin
      int unsigned rand_base;
      int unsigned w_raw;
      int unsigned h_raw;
      int unsigned area;
      tracker     = new();
      quiet       = 1'b0;
      hold_long   = 1'b0;
      pixels_sent = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 24'd0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = 3'd0;
      csr_pwdata  = 32'd0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry, top row only: border pass-through with doubling
      csr_read_check(REG_FRAME_WIDTH);
      csr_read_check(REG_FRAME_HEIGHT);
      send_pixel(BLACK, BLACK, BLACK);
      send_pixel(WHITE, WHITE, WHITE);
      send_pixel(WHITE, BLACK, BLACK);
      send_pixel(BLACK, WHITE, BLACK);
      send_pixel(BLACK, BLACK, WHITE);
      send_pixel(8'd127, 8'd128, 8'd1);
      send_pixel(8'd128, 8'd127, 8'd200);

      // shrink below the clamp mid-row: row ends at once, 3x3 from here
      program_geometry(0, 3);
      send_pixel(WHITE, WHITE, WHITE);
      send_pixel(BLACK, BLACK, BLACK);
      send_pixel(BLACK, BLACK, BLACK);
      send_pixel(WHITE, WHITE, WHITE);
      send_pixel(WHITE, WHITE, WHITE);
      send_pixel(BLACK, BLACK, BLACK);

      // both gradients saturate with opposite signs, and so does their sum
      send_pixel(WHITE, WHITE, WHITE);
      send_pixel(WHITE, WHITE, WHITE);
      send_pixel(BLACK, BLACK, BLACK);
      send_pixel(WHITE, WHITE, WHITE);
      send_pixel(WHITE, WHITE, WHITE);
      send_pixel(BLACK, BLACK, BLACK);
      send_pixel(BLACK, BLACK, BLACK);
      send_pixel(BLACK, BLACK, BLACK);
      send_pixel(BLACK, BLACK, BLACK);

      // widest frame (width clamps to max), part of its top row, with a long
      // output stall up front
      program_geometry(2047, 2);
      quiet     = 1'b1;
      hold_long = 1'b1;
      send_noise(WIDE_PIXELS);
      quiet     = 1'b0;

      // tallest register setting, then cut the frame short by shrinking height
      program_geometry(3, 4095);
      send_noise(60);
      program_geometry(3, 3);
      align_frame();

      rand_base = pixels_sent;
      while (pixels_sent - rand_base < RANDOM_PIXELS) begin
         quiet = ($urandom_range(0, 3) == 0);
         w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
         h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         program_geometry(w_raw, h_raw);
         area = tracker.width_eff() * tracker.height_eff();
         if ($urandom_range(0, 3) == 0) begin
            // width may not grow mid-frame; height may go either way
            send_noise($urandom_range(1, area - 1));
            program_geometry($urandom_range(3, tracker.width_eff()), $urandom_range(3, 8));
            send_noise($urandom_range(0, 20));
            align_frame();
         end else begin
            send_noise(area * $urandom_range(1, 2));
         end
      end

      quiet = 1'b0;
      wait_idle();
      if (tracker.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
